// ----- sv/rmrc_pkg.sv -----
// Shared types, constants and helpers of the rate-match ratio control block.
package rmrc_pkg;

	localparam int FF_DEPTH_LOG2   = 14;
	localparam int PROP_DEPTH_LOG2 = 14;
	localparam int FF_DEPTH        = 1 << FF_DEPTH_LOG2;
	localparam int PROP_DEPTH      = 1 << PROP_DEPTH_LOG2;
	localparam int WIN_LOG2_MIN    = 4;
	localparam int WIN_LOG2_MAX    = 14;

	localparam int DIV_W     = 56;
	localparam int DIV_CNT_W = 6;
	localparam int DIVISOR_W = 32;

	localparam logic [31:0] ONE_Q24  = 32'd16777216;
	localparam logic [24:0] RATIO_LO = 25'd16106127;
	localparam logic [24:0] RATIO_HI = 25'd17448305;

	localparam logic [2:0] REG_FF_WIN    = 3'd0;
	localparam logic [2:0] REG_FF_MIN    = 3'd1;
	localparam logic [2:0] REG_PROP_WIN  = 3'd2;
	localparam logic [2:0] REG_PROP_MIN  = 3'd3;
	localparam logic [2:0] REG_NOMINAL   = 3'd4;
	localparam logic [2:0] REG_INV_NOM   = 3'd5;
	localparam logic [2:0] REG_SMOOTHING = 3'd6;
	localparam logic [2:0] REG_GAIN      = 3'd7;

	typedef struct packed {
		logic signed [14:0] rate_change;
		logic signed [15:0] fill_deviation;
	} in_word_t;

	typedef struct packed {
		logic [24:0]        resample_ratio;
		logic [31:0]        ff_estimate;
		logic signed [23:0] average_deviation;
	} out_word_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_DIVS, S_DIV1, S_MA, S_MB, S_DIV2S, S_DIV2,
		S_CUR, S_SAT, S_SM1, S_SM2, S_SM3, S_T1, S_T2, S_T3, S_OUT
	} state_t;

	// clamp a window log2 register into the legal and ring-fitting range
	function automatic logic [3:0] win_log2(input logic [3:0] lg, input logic [3:0] depth_lg);
		logic [3:0] c;
		c = lg;
		if (c < 4'(WIN_LOG2_MIN)) c = 4'(WIN_LOG2_MIN);
		if (c > 4'(WIN_LOG2_MAX)) c = 4'(WIN_LOG2_MAX);
		if (c > depth_lg) c = depth_lg;
		return c;
	endfunction

endpackage

// ----- sv/rmrc_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module rmrc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rmrc_pkg::DIV_W-1:0]      dividend,
	input  logic [rmrc_pkg::DIVISOR_W-1:0]  divisor,
	output logic                            done,
	output logic [rmrc_pkg::DIV_W-1:0]      quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [rmrc_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [rmrc_pkg::DIV_W-1:0]        quo_q;
	logic [rmrc_pkg::DIVISOR_W-1:0]    rem_q;
	logic [rmrc_pkg::DIVISOR_W-1:0]    div_q;
	logic [rmrc_pkg::DIVISOR_W:0]      rem_try;
	logic [rmrc_pkg::DIVISOR_W:0]      rem_sub;
	logic                              qbit;

	assign rem_try = {rem_q, quo_q[rmrc_pkg::DIV_W-1]};
	assign rem_sub = rem_try - {1'b0, div_q};
	assign qbit    = (rem_try >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rmrc_pkg::DIV_CNT_W'(rmrc_pkg::DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) busy_q <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// shift the dividend out at the top, the quotient in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[rmrc_pkg::DIV_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[rmrc_pkg::DIVISOR_W-1:0] : rem_try[rmrc_pkg::DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/rate_match_ratio_control_unit.sv -----
// Top level of the rate-match ratio control: windows, sequencer and output register.
// The result takes one pass through the feed-forward divider, two when the
// feed-forward ratio is blended toward nominal. One word is in work at a time;
// the next word is taken while a finished result still waits in the output register.
// Reset: asynchronous, clears sums, loads and indexes, sets the smoothed estimate to 1.0
// and the registers to their defaults; ring contents stay undefined until written.
module rate_match_ratio_control_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rmrc_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rmrc_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [39:0]         cfg_data
);

	// configuration registers
	logic [3:0]  ff_win_q, prop_win_q;
	logic [14:0] ff_min_q, prop_min_q;
	logic [31:0] nominal_q, inv_nom_q;
	logic [15:0] smoothing_q;
	logic [39:0] gain_q;

	// window state
	logic [rmrc_pkg::FF_DEPTH_LOG2-1:0]   ff_index_q;
	logic [rmrc_pkg::PROP_DEPTH_LOG2-1:0] prop_index_q;
	logic [14:0] ff_load_q, prop_load_q;
	logic [31:0] pos_sum_q, neg_sum_q;
	logic signed [31:0] prop_sum_q;
	logic [31:0] smoothed_q;

	// rings
	logic signed [14:0] ff_mem [rmrc_pkg::FF_DEPTH];
	logic signed [15:0] prop_mem [rmrc_pkg::PROP_DEPTH];
	logic signed [14:0] ff_rd_q;
	logic signed [15:0] prop_rd_q;

	// work registers
	rmrc_pkg::state_t state_q, state_d;
	rmrc_pkg::in_word_t word_q;
	logic        hold_q, blend_q, mean_use_q, mean_neg_q;
	logic [31:0] raw_q, r_q, cur_q;
	logic [46:0] p1_q, p2_q;
	logic [63:0] prod_q;
	logic [47:0] m1_q;
	logic [48:0] m2_q;
	logic [23:0] mag_q;
	logic [43:0] tlo_q, thi_q;
	logic [39:0] term_q;
	logic        out_valid_q;
	rmrc_pkg::out_word_t out_q;

	// window lengths and masks
	logic [3:0]  ff_lg, prop_lg;
	logic [14:0] ff_w, prop_w;
	logic [rmrc_pkg::FF_DEPTH_LOG2-1:0]   ff_idx;
	logic [rmrc_pkg::PROP_DEPTH_LOG2-1:0] prop_idx;

	assign ff_lg    = rmrc_pkg::win_log2(ff_win_q, 4'(rmrc_pkg::FF_DEPTH_LOG2));
	assign prop_lg  = rmrc_pkg::win_log2(prop_win_q, 4'(rmrc_pkg::PROP_DEPTH_LOG2));
	assign ff_w     = 15'd1 << ff_lg;
	assign prop_w   = 15'd1 << prop_lg;
	assign ff_idx   = ff_index_q & rmrc_pkg::FF_DEPTH_LOG2'(ff_w - 15'd1);
	assign prop_idx = prop_index_q & rmrc_pkg::PROP_DEPTH_LOG2'(prop_w - 15'd1);

	// window update terms
	logic        ff_full, prop_full;
	logic [31:0] old_mag, new_mag;
	logic [31:0] pos_next, neg_next;
	logic signed [31:0] prop_next;

	assign ff_full   = (ff_load_q >= ff_w);
	assign prop_full = (prop_load_q >= prop_w);
	assign old_mag   = ff_rd_q[14] ? 32'(-32'(ff_rd_q)) : 32'(ff_rd_q);
	assign new_mag   = word_q.rate_change[14] ? 32'(-32'(word_q.rate_change))
	                                          : 32'(word_q.rate_change);

	always_comb begin
		pos_next = pos_sum_q;
		neg_next = neg_sum_q;
		// drop the oldest entry once the window is full
		if (ff_full) begin
			if (ff_rd_q[14]) neg_next = neg_next - old_mag;
			else pos_next = pos_next - old_mag;
		end
		if (word_q.rate_change[14]) neg_next = neg_next + new_mag;
		else pos_next = pos_next + new_mag;
		prop_next = prop_sum_q + 32'(word_q.fill_deviation);
		if (prop_full) prop_next = prop_next - 32'(prop_rd_q);
	end

	// dividers
	logic ffd_start, ffd_done, pd_start, pd_done;
	logic [rmrc_pkg::DIV_W-1:0] ffd_dividend, ffd_quo, pd_dividend, pd_quo;
	logic [rmrc_pkg::DIVISOR_W-1:0] ffd_divisor, pd_divisor;
	logic [31:0] prop_abs;
	logic [31:0] raw_sat;

	assign prop_abs  = prop_sum_q[31] ? 32'(-prop_sum_q) : 32'(prop_sum_q);
	assign ffd_start = (state_q == rmrc_pkg::S_DIVS) || (state_q == rmrc_pkg::S_DIV2S);
	assign pd_start  = (state_q == rmrc_pkg::S_DIVS);
	assign raw_sat   = (ffd_quo[55:32] != '0) ? 32'hFFFF_FFFF : ffd_quo[31:0];

	always_comb begin
		if (state_q == rmrc_pkg::S_DIV2S) begin
			ffd_dividend = {8'd0, {1'b0, p1_q} + {1'b0, p2_q}};
			ffd_divisor  = {17'd0, ff_min_q};
		end else begin
			ffd_dividend = {neg_sum_q, 24'd0};
			ffd_divisor  = pos_sum_q;
		end
	end

	assign pd_dividend = {16'd0, prop_abs, 8'd0};
	assign pd_divisor  = {17'd0, prop_load_q};

	rmrc_div u_ff_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ffd_start),
		.dividend (ffd_dividend),
		.divisor  (ffd_divisor),
		.done     (ffd_done),
		.quotient (ffd_quo)
	);

	rmrc_div u_prop_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pd_start),
		.dividend (pd_dividend),
		.divisor  (pd_divisor),
		.done     (pd_done),
		.quotient (pd_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rmrc_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rmrc_pkg::S_IDLE:  if (in_valid) state_d = rmrc_pkg::S_RD;
			rmrc_pkg::S_RD:    state_d = rmrc_pkg::S_DIVS;
			rmrc_pkg::S_DIVS:  state_d = rmrc_pkg::S_DIV1;
			rmrc_pkg::S_DIV1: begin
				if (ffd_done) begin
					if (hold_q) state_d = rmrc_pkg::S_T1;
					else if (blend_q) state_d = rmrc_pkg::S_MA;
					else state_d = rmrc_pkg::S_CUR;
				end
			end
			rmrc_pkg::S_MA:    state_d = rmrc_pkg::S_MB;
			rmrc_pkg::S_MB:    state_d = rmrc_pkg::S_DIV2S;
			rmrc_pkg::S_DIV2S: state_d = rmrc_pkg::S_DIV2;
			rmrc_pkg::S_DIV2:  if (ffd_done) state_d = rmrc_pkg::S_CUR;
			rmrc_pkg::S_CUR:   state_d = rmrc_pkg::S_SAT;
			rmrc_pkg::S_SAT:   state_d = rmrc_pkg::S_SM1;
			rmrc_pkg::S_SM1:   state_d = rmrc_pkg::S_SM2;
			rmrc_pkg::S_SM2:   state_d = rmrc_pkg::S_SM3;
			rmrc_pkg::S_SM3:   state_d = rmrc_pkg::S_T1;
			rmrc_pkg::S_T1:    state_d = rmrc_pkg::S_T2;
			rmrc_pkg::S_T2:    state_d = rmrc_pkg::S_T3;
			rmrc_pkg::S_T3:    state_d = rmrc_pkg::S_OUT;
			rmrc_pkg::S_OUT:   if (!out_valid_q || out_ready) state_d = rmrc_pkg::S_IDLE;
			default:           state_d = rmrc_pkg::S_IDLE;
		endcase
	end

	assign in_ready = (state_q == rmrc_pkg::S_IDLE);

	// rings: read the oldest entry on accept, overwrite it in the cycle after
	always_ff @(posedge clk) begin
		if (state_q == rmrc_pkg::S_IDLE) begin
			ff_rd_q   <= ff_mem[ff_idx];
			prop_rd_q <= prop_mem[prop_idx];
		end
		if (state_q == rmrc_pkg::S_RD) begin
			ff_mem[ff_idx]     <= word_q.rate_change;
			prop_mem[prop_idx] <= word_q.fill_deviation;
		end
	end

	// configuration and window state; a write to registers 0..5 restarts the windows and the smoothed estimate
	logic restart;
	assign restart = cfg_we && (cfg_index <= rmrc_pkg::REG_INV_NOM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_win_q     <= 4'd14;
			ff_min_q     <= 15'd4096;
			prop_win_q   <= 4'd14;
			prop_min_q   <= 15'd4096;
			nominal_q    <= rmrc_pkg::ONE_Q24;
			inv_nom_q    <= rmrc_pkg::ONE_Q24;
			smoothing_q  <= 16'd655;
			gain_q       <= 40'd4398047;
			ff_index_q   <= '0;
			prop_index_q <= '0;
			ff_load_q    <= '0;
			prop_load_q  <= '0;
			pos_sum_q    <= '0;
			neg_sum_q    <= '0;
			prop_sum_q   <= '0;
			smoothed_q   <= rmrc_pkg::ONE_Q24;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rmrc_pkg::REG_FF_WIN:    ff_win_q    <= cfg_data[3:0];
					rmrc_pkg::REG_FF_MIN:    ff_min_q    <= cfg_data[14:0];
					rmrc_pkg::REG_PROP_WIN:  prop_win_q  <= cfg_data[3:0];
					rmrc_pkg::REG_PROP_MIN:  prop_min_q  <= cfg_data[14:0];
					rmrc_pkg::REG_NOMINAL:   nominal_q   <= cfg_data[31:0];
					rmrc_pkg::REG_INV_NOM:   inv_nom_q   <= cfg_data[31:0];
					rmrc_pkg::REG_SMOOTHING: smoothing_q <= cfg_data[15:0];
					rmrc_pkg::REG_GAIN:      gain_q      <= cfg_data;
					default: ;
				endcase
			end
			if (restart) begin
				ff_index_q   <= '0;
				prop_index_q <= '0;
				ff_load_q    <= '0;
				prop_load_q  <= '0;
				pos_sum_q    <= '0;
				neg_sum_q    <= '0;
				prop_sum_q   <= '0;
				smoothed_q   <= rmrc_pkg::ONE_Q24;
			end else if (state_q == rmrc_pkg::S_RD) begin
				pos_sum_q    <= pos_next;
				neg_sum_q    <= neg_next;
				prop_sum_q   <= prop_next;
				if (!ff_full) ff_load_q <= ff_load_q + 15'd1;
				if (!prop_full) prop_load_q <= prop_load_q + 15'd1;
				ff_index_q   <= (ff_idx + 1'b1) & rmrc_pkg::FF_DEPTH_LOG2'(ff_w - 15'd1);
				prop_index_q <= (prop_idx + 1'b1) & rmrc_pkg::PROP_DEPTH_LOG2'(prop_w - 15'd1);
			end else if (state_q == rmrc_pkg::S_SM3) begin
				// blend new estimate into the running one, Q0.16 weight
				smoothed_q <= 32'(({1'b0, m1_q} + m2_q) >> 16);
			end
		end
	end

	// datapath; payload registers carry no reset
	logic signed [41:0] var_raw;
	logic [64:0] term_sum;

	assign term_sum = {1'b0, thi_q, 20'd0} + {21'd0, tlo_q};
	assign var_raw  = mean_neg_q ? $signed({10'd0, smoothed_q}) + $signed({2'd0, term_q})
	                             : $signed({10'd0, smoothed_q}) - $signed({2'd0, term_q});

	always_ff @(posedge clk) begin
		case (state_q)
			rmrc_pkg::S_IDLE: if (in_valid) word_q <= in_data;
			rmrc_pkg::S_DIVS: begin
				// pick the feed-forward path from the updated sums
				hold_q     <= (ff_load_q >= ff_min_q) && (pos_sum_q == '0);
				blend_q    <= (ff_load_q < ff_min_q) && (pos_sum_q != '0) && (neg_sum_q != '0);
				mean_use_q <= (prop_load_q >= prop_min_q);
				mean_neg_q <= prop_sum_q[31];
				r_q        <= nominal_q;
			end
			rmrc_pkg::S_DIV1: begin
				if (ffd_done) begin
					raw_q <= raw_sat;
					if (ff_load_q >= ff_min_q) r_q <= raw_sat;
				end
				if (pd_done) mag_q <= mean_use_q ? pd_quo[23:0] : 24'd0;
			end
			rmrc_pkg::S_MA: p1_q <= nominal_q * (ff_min_q - ff_load_q);
			rmrc_pkg::S_MB: p2_q <= raw_q * ff_load_q;
			rmrc_pkg::S_DIV2: if (ffd_done) r_q <= ffd_quo[31:0];
			rmrc_pkg::S_CUR: prod_q <= r_q * inv_nom_q;
			rmrc_pkg::S_SAT: cur_q <= (prod_q[63:56] != '0) ? 32'hFFFF_FFFF : prod_q[55:24];
			rmrc_pkg::S_SM1: m1_q <= smoothing_q * cur_q;
			rmrc_pkg::S_SM2: m2_q <= (17'h10000 - {1'b0, smoothing_q}) * smoothed_q;
			rmrc_pkg::S_T1:  tlo_q <= gain_q[19:0] * mag_q;
			rmrc_pkg::S_T2:  thi_q <= gain_q[39:20] * mag_q;
			rmrc_pkg::S_T3:  term_q <= term_sum[63:24];
			default: ;
		endcase
	end

	// output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rmrc_pkg::S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rmrc_pkg::S_OUT && (!out_valid_q || out_ready)) begin
			if (var_raw > $signed({17'd0, rmrc_pkg::RATIO_HI}))
				out_q.resample_ratio <= rmrc_pkg::RATIO_HI;
			else if (var_raw < $signed({17'd0, rmrc_pkg::RATIO_LO}))
				out_q.resample_ratio <= rmrc_pkg::RATIO_LO;
			else
				out_q.resample_ratio <= var_raw[24:0];
			out_q.ff_estimate       <= smoothed_q;
			out_q.average_deviation <= mean_neg_q ? -$signed(mag_q) : $signed(mag_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
